@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the RTL, included by the top level.
// Expects clk_i and rst_ni (active low) in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked at every rising edge outside reset.
`define SWMA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in this cycle implies a consequence in the next cycle.
`define SWMA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/swma_pkg.sv @@
// Shared types and constants for the six-axis weighted moving average.
// No dependencies; used by swma_cell, swma_lane and the top level.
`default_nettype none

package swma_pkg;

  // Sample and result width
  localparam int unsigned DATA_W = 16;

  // Saturation bounds of a result
  localparam logic signed [DATA_W-1:0] DATA_MAX = 16'sh7fff;
  localparam logic signed [DATA_W-1:0] DATA_MIN = 16'sh8000;

  // Stages after the history state: magnitude, estimate, product, quotient, output
  localparam int unsigned PIPE_DEPTH = 5;

  // Configuration register index
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GYRO_PITCH_OFS = 3'd0,
    REG_GYRO_ROLL_OFS  = 3'd1,
    REG_GYRO_YAW_OFS   = 3'd2,
    REG_ACCEL_X_OFS    = 3'd3,
    REG_ACCEL_Y_OFS    = 3'd4,
    REG_ACCEL_Z_OFS    = 3'd5
  } swma_reg_e;

  // Pipeline control handed from the top level to every lane
  typedef struct packed {
    logic                  push;  // input transfer: shift the history
    logic [PIPE_DEPTH-1:0] adv;   // stage k+1 loads from stage k
  } swma_ctrl_t;

endpackage

`default_nettype wire

@@ hw/rtl/swma_cell.sv @@
// One tap of an axis history line: a sample register that loads from its
// neighbor (cell 0 from the input sample) on every shift. Depends on swma_pkg.
`default_nettype none

module swma_cell (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               en_i,
  input  wire logic signed [swma_pkg::DATA_W-1:0] d_i,
  output logic signed      [swma_pkg::DATA_W-1:0] q_o
);

  logic signed [swma_pkg::DATA_W-1:0] tap_q;

  // History starts at zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tap_q <= '0;
    end else if (en_i) begin
      tap_q <= d_i;
    end
  end

  assign q_o = tap_q;

endmodule

`default_nettype wire

@@ hw/rtl/swma_lane.sv @@
// One axis: a chain of history cells, running plain and weighted sums,
// division by the weight total, offset and saturation. Depends on swma_pkg, swma_cell.
`default_nettype none

module swma_lane #(
  parameter int unsigned TAPS = 8
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire swma_pkg::swma_ctrl_t               ctrl_i,
  input  wire logic signed [swma_pkg::DATA_W-1:0] sample_i,
  input  wire logic signed [swma_pkg::DATA_W-1:0] offset_i,
  output logic signed      [swma_pkg::DATA_W-1:0] smooth_o
);

  localparam int unsigned DW     = swma_pkg::DATA_W;
  // Weight total N(N+1)/2 and the widths it implies
  localparam int unsigned DIV    = TAPS * (TAPS + 1) / 2;
  localparam int unsigned DIV_W  = $clog2(DIV + 1);
  localparam int unsigned SUM_W  = DW + DIV_W;      // |sum| <= 32768 * DIV
  localparam int unsigned MAG_W  = SUM_W - 1;
  localparam int unsigned EXT_W  = SUM_W + 2;
  localparam int unsigned QUO_W  = DW;              // quotient <= 32768
  localparam int unsigned PROD_W = 2 * MAG_W + 1;
  localparam int unsigned OUT_W  = DW + 2;
  // Reciprocal floor(2^MAG_W / DIV): estimate is exact or one short
  localparam logic [MAG_W:0]   RECIP   = (MAG_W + 1)'((64'd1 << MAG_W) / DIV);
  localparam logic [MAG_W-1:0] DIV_MAG = MAG_W'(DIV);

  // ------------------------------------------------------------------
  // History line: cell 0 newest, cell TAPS-1 oldest
  logic signed [DW-1:0] tap [TAPS];

  for (genvar k = 0; k < TAPS; k++) begin : g_cell
    if (k == 0) begin : g_head
      swma_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (ctrl_i.push),
        .d_i    (sample_i),
        .q_o    (tap[k])
      );
    end else begin : g_body
      swma_cell u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .en_i   (ctrl_i.push),
        .d_i    (tap[k-1]),
        .q_o    (tap[k])
      );
    end
  end

  // ------------------------------------------------------------------
  // Running sums: S' = S + x - oldest, W' = W + N*x - S
  logic signed [SUM_W-1:0] sum_q, sum_d;
  logic signed [SUM_W-1:0] wsum_q, wsum_d;
  logic signed [EXT_W-1:0] sum_ext, wsum_ext;

  always_comb begin
    sum_ext  = EXT_W'(sum_q) + EXT_W'(sample_i) - EXT_W'(tap[TAPS-1]);
    wsum_ext = EXT_W'(wsum_q) + EXT_W'(TAPS) * EXT_W'(sample_i) - EXT_W'(sum_q);
    sum_d    = sum_ext[SUM_W-1:0];
    wsum_d   = wsum_ext[SUM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q  <= '0;
      wsum_q <= '0;
    end else if (ctrl_i.push) begin
      sum_q  <= sum_d;
      wsum_q <= wsum_d;
    end
  end

  // ------------------------------------------------------------------
  // Stage 1: sign and magnitude
  logic                    neg1_q;
  logic [MAG_W-1:0]        mag1_q;
  logic signed [SUM_W-1:0] wsum_neg;

  assign wsum_neg = -wsum_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[0]) begin
      neg1_q <= wsum_q[SUM_W-1];
      mag1_q <= wsum_q[SUM_W-1] ? wsum_neg[MAG_W-1:0] : wsum_q[MAG_W-1:0];
    end
  end

  // Stage 2: quotient estimate by reciprocal multiply
  logic              neg2_q;
  logic [MAG_W-1:0]  mag2_q;
  logic [QUO_W-1:0]  qest2_q;
  logic [PROD_W-1:0] recip_prod;

  assign recip_prod = PROD_W'(mag1_q) * PROD_W'(RECIP);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[1]) begin
      neg2_q  <= neg1_q;
      mag2_q  <= mag1_q;
      qest2_q <= recip_prod[MAG_W+QUO_W-1:MAG_W];
    end
  end

  // Stage 3: estimate times divisor
  logic             neg3_q;
  logic [MAG_W-1:0] mag3_q;
  logic [QUO_W-1:0] qest3_q;
  logic [MAG_W-1:0] qd3_q;
  logic [SUM_W-1:0] qd_full;

  assign qd_full = SUM_W'(qest2_q) * SUM_W'(DIV);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[2]) begin
      neg3_q  <= neg2_q;
      mag3_q  <= mag2_q;
      qest3_q <= qest2_q;
      qd3_q   <= qd_full[MAG_W-1:0];
    end
  end

  // Stage 4: correct by one where the remainder reaches the divisor, restore sign
  logic signed [QUO_W:0] avg4_q;
  logic [MAG_W-1:0]      rem;
  logic [QUO_W:0]        quo;
  logic signed [QUO_W:0] avg_d;

  always_comb begin
    rem   = mag3_q - qd3_q;
    quo   = (QUO_W + 1)'(qest3_q) + (QUO_W + 1)'(rem >= DIV_MAG);
    avg_d = neg3_q ? -$signed(quo) : $signed(quo);
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[3]) begin
      avg4_q <= avg_d;
    end
  end

  // Stage 5: add calibration offset and saturate (output register)
  logic signed [DW-1:0]    smooth_q;
  logic signed [OUT_W-1:0] total;
  logic signed [DW-1:0]    smooth_d;

  always_comb begin
    total = OUT_W'(avg4_q) + OUT_W'(offset_i);
    if (total > OUT_W'(swma_pkg::DATA_MAX)) begin
      smooth_d = swma_pkg::DATA_MAX;
    end else if (total < OUT_W'(swma_pkg::DATA_MIN)) begin
      smooth_d = swma_pkg::DATA_MIN;
    end else begin
      smooth_d = total[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv[4]) begin
      smooth_q <= smooth_d;
    end
  end

  assign smooth_o = smooth_q;

endmodule

`default_nettype wire

@@ hw/rtl/six_axis_weighted_moving_average.sv @@
// Six-axis weighted moving average filter, top level.
// Depends on swma_pkg, swma_lane, swma_cell and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one six-axis sample per
//   transfer. Output channel (out_valid_o / out_ready_i) returns one smoothed
//   six-axis result per input, in order. Each axis keeps its own history:
//   gyro axes over GYRO_TAPS samples, accelerometer axes over ACCEL_TAPS.
//   Weights run from N (newest) to 1 (oldest); the weighted sum is divided by
//   N(N+1)/2 truncating toward zero, the axis offset is added and the result
//   saturates to signed 16 bit.
//   A result passes the running-sum state and then the divide-by-constant
//   pipeline (reciprocal multiply, back multiply, correct) plus offset and
//   saturation. Throughput: one sample per cycle while in_ready_o is high; the
//   history cells and running sums update in the cycle of the transfer.
//   When the receiver stalls, the pipeline holds its result and keeps taking
//   inputs until every stage is full, then drops in_ready_o.
//   Reset clears all histories, sums and offsets to zero; no clearing pass.
//   Offsets are written through cfg_we_i / cfg_idx_i / cfg_wdata_i by the user
//   only while idle, not enforced by the block; indexes above 5 are ignored.
`default_nettype none
`include "assert_macros.svh"

module six_axis_weighted_moving_average #(
  parameter int unsigned GYRO_TAPS  = 8,
  parameter int unsigned ACCEL_TAPS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write port
  input  wire logic                                cfg_we_i,
  input  wire logic [swma_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [swma_pkg::DATA_W-1:0]         cfg_wdata_i,
  // Input samples
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [swma_pkg::DATA_W-1:0]  accel_x_raw_i,
  input  wire logic signed [swma_pkg::DATA_W-1:0]  accel_y_raw_i,
  input  wire logic signed [swma_pkg::DATA_W-1:0]  accel_z_raw_i,
  input  wire logic signed [swma_pkg::DATA_W-1:0]  gyro_pitch_raw_i,
  input  wire logic signed [swma_pkg::DATA_W-1:0]  gyro_roll_raw_i,
  input  wire logic signed [swma_pkg::DATA_W-1:0]  gyro_yaw_raw_i,
  // Smoothed results
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [swma_pkg::DATA_W-1:0]       accel_x_smooth_o,
  output logic signed [swma_pkg::DATA_W-1:0]       accel_y_smooth_o,
  output logic signed [swma_pkg::DATA_W-1:0]       accel_z_smooth_o,
  output logic signed [swma_pkg::DATA_W-1:0]       gyro_pitch_smooth_o,
  output logic signed [swma_pkg::DATA_W-1:0]       gyro_roll_smooth_o,
  output logic signed [swma_pkg::DATA_W-1:0]       gyro_yaw_smooth_o
);

  localparam int unsigned DW    = swma_pkg::DATA_W;
  localparam int unsigned DEPTH = swma_pkg::PIPE_DEPTH;

  // ------------------------------------------------------------------
  // Offset registers
  logic signed [DW-1:0] gyro_pitch_ofs_q, gyro_roll_ofs_q, gyro_yaw_ofs_q;
  logic signed [DW-1:0] accel_x_ofs_q, accel_y_ofs_q, accel_z_ofs_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gyro_pitch_ofs_q <= '0;
      gyro_roll_ofs_q  <= '0;
      gyro_yaw_ofs_q   <= '0;
      accel_x_ofs_q    <= '0;
      accel_y_ofs_q    <= '0;
      accel_z_ofs_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (swma_pkg::swma_reg_e'(cfg_idx_i))
        swma_pkg::REG_GYRO_PITCH_OFS: gyro_pitch_ofs_q <= cfg_wdata_i;
        swma_pkg::REG_GYRO_ROLL_OFS:  gyro_roll_ofs_q  <= cfg_wdata_i;
        swma_pkg::REG_GYRO_YAW_OFS:   gyro_yaw_ofs_q   <= cfg_wdata_i;
        swma_pkg::REG_ACCEL_X_OFS:    accel_x_ofs_q    <= cfg_wdata_i;
        swma_pkg::REG_ACCEL_Y_OFS:    accel_y_ofs_q    <= cfg_wdata_i;
        swma_pkg::REG_ACCEL_Z_OFS:    accel_z_ofs_q    <= cfg_wdata_i;
        default: ;  // unknown index: ignored
      endcase
    end
  end

  // ------------------------------------------------------------------
  // Stage valid bits: bit 0 is the running-sum state, bit DEPTH the output
  logic [DEPTH:0] valid_q, valid_d;
  logic [DEPTH:0] adv;
  logic           push;
  swma_pkg::swma_ctrl_t ctrl;

  // A stage moves when it is empty or the one after it moves
  always_comb begin
    adv[DEPTH] = !valid_q[DEPTH] || out_ready_i;
    for (int k = DEPTH - 1; k >= 0; k--) begin
      adv[k] = !valid_q[k] || adv[k+1];
    end
    push = in_valid_i && adv[0];
    valid_d = valid_q;
    if (adv[0]) begin
      valid_d[0] = in_valid_i;
    end
    for (int k = 1; k <= DEPTH; k++) begin
      if (adv[k]) begin
        valid_d[k] = valid_q[k-1];
      end
    end
    ctrl.push = push;
    ctrl.adv  = adv[DEPTH:1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = valid_q[DEPTH];

  // ------------------------------------------------------------------
  // Accelerometer lanes
  swma_lane #(.TAPS(ACCEL_TAPS)) u_accel_x (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (accel_x_raw_i),
    .offset_i (accel_x_ofs_q),
    .smooth_o (accel_x_smooth_o)
  );

  swma_lane #(.TAPS(ACCEL_TAPS)) u_accel_y (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (accel_y_raw_i),
    .offset_i (accel_y_ofs_q),
    .smooth_o (accel_y_smooth_o)
  );

  swma_lane #(.TAPS(ACCEL_TAPS)) u_accel_z (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (accel_z_raw_i),
    .offset_i (accel_z_ofs_q),
    .smooth_o (accel_z_smooth_o)
  );

  // Gyro lanes
  swma_lane #(.TAPS(GYRO_TAPS)) u_gyro_pitch (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (gyro_pitch_raw_i),
    .offset_i (gyro_pitch_ofs_q),
    .smooth_o (gyro_pitch_smooth_o)
  );

  swma_lane #(.TAPS(GYRO_TAPS)) u_gyro_roll (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (gyro_roll_raw_i),
    .offset_i (gyro_roll_ofs_q),
    .smooth_o (gyro_roll_smooth_o)
  );

  swma_lane #(.TAPS(GYRO_TAPS)) u_gyro_yaw (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .sample_i (gyro_yaw_raw_i),
    .offset_i (gyro_yaw_ofs_q),
    .smooth_o (gyro_yaw_smooth_o)
  );

  // ------------------------------------------------------------------
  // Assertions
  `SWMA_ASSERT(a_full_when_blocked, !in_ready_o |-> (&valid_q),
    "input blocked while a pipeline stage is empty")
  `SWMA_ASSERT_NEXT(a_push_fills_state, in_valid_i && in_ready_o, valid_q[0],
    "input transfer did not mark the sum stage valid")
  `SWMA_ASSERT_NEXT(a_result_held, out_valid_o && !out_ready_i, out_valid_o,
    "stalled result dropped before its transfer")

endmodule

`default_nettype wire
